>>> design/f2p_pkg.sv
// shared types and constants of the float to 24-bit pcm converter
package f2p_pkg;

  localparam logic [22:0] PLAIN_SCALE = 23'h7FFFFF;
  localparam logic [9:0]  CLIP_EXP_OFS = 10'd31;
  localparam logic [9:0]  EXP_UNIT = 10'd150;
  localparam logic [9:0]  EXP_SAT = 10'd158;
  localparam logic [7:0]  EXP_SPECIAL = 8'hFF;
  localparam logic [31:0] POS_SAT = 32'h7FFFFFFF;
  localparam logic [31:0] NEG_SAT = 32'h80000000;

  typedef enum logic [0:0] {
    REG_BIG_ENDIAN = 1'b0,
    REG_CLIP_MODE  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] sample_bits;
    logic        last_in;
  } in_t;

  typedef struct packed {
    logic [7:0] byte_first;
    logic [7:0] byte_middle;
    logic [7:0] byte_final;
    logic       last_out;
  } out_t;

  // value = man * 2^(ex_eff - 150), with special flags
  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        zero;
    logic        neg;
    logic [9:0]  ex_eff;
    logic [23:0] man;
  } num_t;

endpackage

>>> design/f2p_stream_if.sv
// valid/ready stream interface carrying one payload
interface f2p_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/float_to_pcm24.sv
// top level: float32 audio sample to three packed 24-bit pcm bytes
//
// in_ch takes one float32 sample bit pattern and a last flag per transfer;
// out_ch gives the three bytes in memory order and the copied last flag.
// cfg_we/cfg_index/cfg_data write big_endian (index 0) and clip_mode
// (index 1); change them only while no sample is in flight.
// four register stages: decode and multiply, normalize and round to single
// precision, round to integer with saturation and negate, then pack the
// bytes; each result passes these registers in order to out_ch.
// throughput is one sample per cycle while out_ch is not stalled.
// when the receiver stalls with a sample waiting on out_ch, the whole
// pipeline holds and in_ch.ready drops; while out_ch holds no sample the
// pipeline keeps moving even with out_ch.ready low.
// reset empties the pipeline and loads big_endian 0, clip_mode 1.
module float_to_pcm24 import f2p_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  f2p_stream_if.sink    in_ch,
  f2p_stream_if.source  out_ch,
  input  logic          cfg_we,
  input  reg_idx_t      cfg_index,
  input  logic          cfg_data
);

  logic big_endian;
  logic clip_mode;
  logic adv;

  logic        v1, v2, v3, v4;
  logic        s1_nan, s1_inf, s1_neg, s1_sub, s1_last;
  logic [7:0]  s1_ex;
  logic [23:0] s1_man;
  logic [46:0] s1_prod;
  num_t        s2;
  num_t        s2_next;
  logic        s2_last;
  logic [31:0] s3_val;
  logic [31:0] s3_val_next;
  logic        s3_last;
  out_t        out_data;
  out_t        out_next;

  logic [7:0]  in_ex;
  logic [22:0] in_frac;
  logic [23:0] keep;
  logic        up;
  logic [24:0] rsum;
  logic [23:0] pv;

  assign adv = !v4 || out_ch.ready;
  assign in_ch.ready = adv;
  assign out_ch.valid = v4;
  assign out_ch.data = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      big_endian <= 1'b0;
      clip_mode  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BIG_ENDIAN: big_endian <= cfg_data;
        REG_CLIP_MODE:  clip_mode  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ex   = in_ch.data.sample_bits[30:23];
  assign in_frac = in_ch.data.sample_bits[22:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= in_ch.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // decode and multiply
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_nan  <= (in_ex == EXP_SPECIAL) && (in_frac != 23'd0);
      s1_inf  <= (in_ex == EXP_SPECIAL) && (in_frac == 23'd0);
      s1_neg  <= in_ch.data.sample_bits[31];
      s1_sub  <= (in_ex == 8'd0);
      s1_ex   <= (in_ex == 8'd0) ? 8'd1 : in_ex;
      s1_man  <= {(in_ex != 8'd0), in_frac};
      s1_prod <= {(in_ex != 8'd0), in_frac} * PLAIN_SCALE;
      s1_last <= in_ch.data.last_in;
    end
  end

  // normalize, round product to single precision; clip mode scales by 2^31
  always_comb begin
    keep = s1_prod[46] ? s1_prod[46:23] : s1_prod[45:22];
    if (s1_prod[46]) begin
      up = s1_prod[22] && ((|s1_prod[21:0]) || keep[0]);
    end else begin
      up = s1_prod[21] && ((|s1_prod[20:0]) || keep[0]);
    end
    rsum = {1'b0, keep} + {24'd0, up};
    s2_next.nan = s1_nan;
    s2_next.inf = s1_inf;
    s2_next.neg = s1_neg;
    if (clip_mode) begin
      s2_next.zero   = 1'b0;
      s2_next.ex_eff = {2'd0, s1_ex} + CLIP_EXP_OFS;
      s2_next.man    = s1_man;
    end else begin
      s2_next.zero   = s1_sub;
      s2_next.ex_eff = {2'd0, s1_ex} + 10'd22 + {9'd0, s1_prod[46]} + {9'd0, rsum[24]};
      s2_next.man    = rsum[24] ? 24'h800000 : rsum[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2      <= s2_next;
      s2_last <= s1_last;
    end
  end

  f2p_round u_round (
    .num (s2),
    .val (s3_val_next)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_val  <= s3_val_next;
      s3_last <= s2_last;
    end
  end

  // pick the 24-bit word and order the bytes
  always_comb begin
    pv = clip_mode ? s3_val[31:8] : s3_val[23:0];
    if (big_endian) begin
      out_next.byte_first = pv[23:16];
      out_next.byte_final = pv[7:0];
    end else begin
      out_next.byte_first = pv[7:0];
      out_next.byte_final = pv[23:16];
    end
    out_next.byte_middle = pv[15:8];
    out_next.last_out    = s3_last;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= out_next;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable({v1, v2, v3, v4}))
    else $error("pipeline moved during a stall");

  a_stage_reaches_out: assert property (@(posedge clk) disable iff (rst)
    (adv && v3) |=> out_ch.valid)
    else $error("sample lost before the output register");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while the pipeline is stalled");

endmodule

>>> design/f2p_round.sv
// rounds a scaled value to nearest even and saturates it to signed 32 bits
module f2p_round import f2p_pkg::*; (
  input  num_t        num,
  output logic [31:0] val
);

  logic [9:0]  sh;
  logic [9:0]  lsh;
  logic [47:0] t;
  logic [24:0] q;
  logic        up;
  logic [31:0] mag;

  always_comb begin
    sh  = EXP_UNIT - num.ex_eff;
    lsh = num.ex_eff - EXP_UNIT;
    t   = {num.man, 24'd0} >> sh[4:0];
    up  = t[23] && ((|t[22:0]) || t[24]);
    q   = {1'b0, t[47:24]} + {24'd0, up};
    mag = 32'd0;
    if (num.ex_eff >= EXP_UNIT) begin
      mag = {8'd0, num.man} << lsh[2:0];
    end else if (sh < 10'd25) begin
      mag = {7'd0, q};
    end
    if (num.nan || num.zero) begin
      val = 32'd0;
    end else if (num.inf || num.ex_eff >= EXP_SAT) begin
      val = num.neg ? NEG_SAT : POS_SAT;
    end else begin
      val = num.neg ? (32'd0 - mag) : mag;
    end
  end

endmodule

>>> dv/f2p_scoreboard.sv
// scoreboard: predicts the pcm bytes of each accepted sample and checks the results
class f2p_scoreboard;
  f2p_pkg::out_t pending[$];
  bit big_endian;
  bit clip_mode;
  int errors;
  int checked;

  function new();
    big_endian = 1'b0;
    clip_mode = 1'b1;
    errors = 0;
    checked = 0;
  endfunction

  function void report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endfunction

  // value m * 2^sh rounded to nearest even, saturated to signed 32 bits
  function logic [31:0] round_int(bit neg, logic [63:0] m, int sh);
    logic [127:0] mag;
    logic [127:0] q;
    logic [127:0] r;
    logic [127:0] half;
    int k;
    mag = 0;
    if (m == 0) return 32'h0;
    if (sh >= 0) begin
      if (sh >= 40) mag = 128'h1 << 40;
      else mag = {64'h0, m} << sh;
    end else begin
      k = -sh;
      if (k >= 64) begin
        mag = 0;
      end else begin
        q = {64'h0, m} >> k;
        r = {64'h0, m} & ((128'h1 << k) - 1);
        half = 128'h1 << (k - 1);
        if (r > half || (r == half && q[0])) q = q + 1;
        mag = q;
      end
    end
    if (neg) begin
      if (mag > 128'h80000000) mag = 128'h80000000;
      return 32'h0 - mag[31:0];
    end
    if (mag > 128'h7FFFFFFF) mag = 128'h7FFFFFFF;
    return mag[31:0];
  endfunction

  function logic [23:0] pcm_value(logic [31:0] fb);
    bit neg;
    int ex;
    logic [63:0] man;
    logic [63:0] prod;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] half;
    int top;
    int s;
    logic [31:0] w;
    neg = fb[31];
    ex = fb[30:23];
    man = {41'h0, fb[22:0]};
    if (ex == 255) begin
      if (man != 0) return 24'h0;
      if (clip_mode) return neg ? 24'h800000 : 24'h7FFFFF;
      return neg ? 24'h000000 : 24'hFFFFFF;
    end
    if (ex == 0) ex = 1;
    else man[23] = 1'b1;
    if (clip_mode) begin
      // scaling by 2^31 is exact, so compare the magnitude directly
      if (man != 0 && ex + 31 - 150 + 24 > 31 + 1) return neg ? 24'h800000 : 24'h7FFFFF;
      if (man != 0 && ex + 31 >= 158 + 0 && (man << (ex + 31 - 150)) >= 64'h80000000)
        return neg ? 24'h800000 : 24'h7FFFFF;
      w = round_int(neg, man, ex + 31 - 150);
      return w[31:8];
    end
    prod = man * 64'd8388607;
    top = -1;
    for (int i = 0; i < 64; i++) if (prod[i]) top = i;
    s = 0;
    if (top >= 24) begin
      s = top - 23;
      q = prod >> s;
      r = prod & ((64'h1 << s) - 1);
      half = 64'h1 << (s - 1);
      if (r > half || (r == half && q[0])) q = q + 1;
      prod = q;
    end
    w = round_int(neg, prod, ex - 150 + s);
    return w[23:0];
  endfunction

  function void note(f2p_pkg::in_t item);
    f2p_pkg::out_t exp_res;
    logic [23:0] v;
    v = pcm_value(item.sample_bits);
    if (big_endian) begin
      exp_res.byte_first = v[23:16];
      exp_res.byte_final = v[7:0];
    end else begin
      exp_res.byte_first = v[7:0];
      exp_res.byte_final = v[23:16];
    end
    exp_res.byte_middle = v[15:8];
    exp_res.last_out = item.last_in;
    pending.push_back(exp_res);
  endfunction

  function void check(f2p_pkg::out_t got);
    f2p_pkg::out_t want;
    if (pending.size() == 0) begin
      report("unexpected result", {8'h0, got.byte_first, got.byte_middle, got.byte_final}, 0);
      return;
    end
    want = pending.pop_front();
    checked++;
    if (got.byte_first != want.byte_first) report("byte_first", got.byte_first, want.byte_first);
    if (got.byte_middle != want.byte_middle)
      report("byte_middle", got.byte_middle, want.byte_middle);
    if (got.byte_final != want.byte_final) report("byte_final", got.byte_final, want.byte_final);
    if (got.last_out != want.last_out) report("last_out", got.last_out, want.last_out);
  endfunction
endclass

>>> dv/float_to_pcm24_test.sv
// testbench top: drives samples and register settings into float_to_pcm24
module float_to_pcm24_test;
  import f2p_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  reg_idx_t cfg_index = REG_BIG_ENDIAN;
  logic cfg_data = 1'b0;
  bit no_stall = 1'b0;
  int n_sent = 0;

  f2p_stream_if #(.payload_t(in_t)) in_if ();
  f2p_stream_if #(.payload_t(out_t)) out_if ();

  f2p_scoreboard pcm_board = new();

  float_to_pcm24 dut (
    .clk(clk), .rst(rst), .in_ch(in_if.sink), .out_ch(out_if.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_stall || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stalls
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (gap_len() > 0) begin
      stall_left <= $urandom_range(0, 12);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_if.valid && out_if.ready) pcm_board.check(out_if.data);
  end

  task automatic send_sample(logic [31:0] bits, logic last);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= '{sample_bits: bits, last_in: last};
    do @(posedge clk); while (!in_if.ready);
    pcm_board.note('{sample_bits: bits, last_in: last});
    n_sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    wait (pcm_board.pending.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_mode(bit be, bit clip);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_BIG_ENDIAN;
    cfg_data <= be;
    @(posedge clk);
    cfg_index <= REG_CLIP_MODE;
    cfg_data <= clip;
    @(posedge clk);
    cfg_we <= 1'b0;
    pcm_board.big_endian = be;
    pcm_board.clip_mode = clip;
  endtask

  function automatic logic [31:0] rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return {1'($urandom), 8'($urandom_range(100, 126)), 23'($urandom)};
    if (r < 70) return {1'($urandom), 8'($urandom_range(126, 127)), 23'($urandom)};
    if (r < 80) return {1'($urandom), 8'($urandom_range(0, 2)), 23'($urandom)};
    return $urandom;
  endfunction

  logic [31:0] corner_list[] = '{
    32'h00000000, 32'h80000000, 32'h3F800000, 32'hBF800000, 32'h3F7FFFFF,
    32'hBF7FFFFF, 32'h7F800000, 32'hFF800000, 32'h7FC00000, 32'hFFFFFFFF,
    32'h7F800001, 32'h00000001, 32'h807FFFFF, 32'h3F000000, 32'h34000000,
    32'h33FFFFFF, 32'h7F7FFFFF, 32'hFF7FFFFF, 32'h4F000000, 32'hCF000000,
    32'h3A800000, 32'h35000000
  };

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // reset settings first, then every combination
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) set_mode(ph[0], ph[1]);
      no_stall = (ph == 2);
      if (ph < 4) foreach (corner_list[i]) send_sample(corner_list[i], 1'($urandom));
      for (int k = 0; k < 112; k++) begin
        if (ph == 3 && k == 60) drain();
        send_sample(rand_sample(), ($urandom_range(0, 7) == 0));
      end
    end
    drain();
    repeat (10) @(posedge clk);
    $display("sent %0d samples, checked %0d results over all byte order and scaling settings",
             n_sent, pcm_board.checked);
    if (pcm_board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", pcm_board.pending.size());
    $display("Simulation FAILED");
    $finish;
  end
endmodule
